// ===== hw/rtl/r332t_pkg.sv =====
`default_nettype none

package r332t_pkg;

  // Arithmetic constants of the blend and the quantizer
  localparam int unsigned FULL_SCALE   = 255;
  localparam int unsigned HALF_ROUND   = 127;
  localparam int unsigned RG_MAX_LEVEL = 7;
  localparam int unsigned B_MAX_LEVEL  = 3;
  localparam int unsigned RED_SHIFT    = 5;
  localparam int unsigned GREEN_SHIFT  = 2;

  // Numerator of the blend when a*(255-c) is zero: 255*255 plus rounding
  localparam int unsigned BLEND_BIAS = FULL_SCALE * FULL_SCALE + HALF_ROUND;

  typedef logic [7:0]  chan_t;
  typedef logic [15:0] blend_num_t;
  typedef logic [8:0]  thresh_t;
  typedef logic [2:0]  rg_level_t;
  typedef logic [1:0]  b_level_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       row_end;
  } pixel_in_t;

  typedef struct packed {
    logic [7:0] packed_pixel;
    logic       row_end_out;
  } pixel_out_t;

  // Sum of the decoded values of levels k and k+1 for the 8-level channels;
  // twice the blended value above this picks a level above k
  function automatic thresh_t rg_thresh(input int unsigned k);
    int unsigned lo;
    int unsigned hi;
    lo = (k * FULL_SCALE) / RG_MAX_LEVEL;
    hi = ((k + 1) * FULL_SCALE) / RG_MAX_LEVEL;
    return thresh_t'(lo + hi);
  endfunction

  // Same for the 4-level blue channel
  function automatic thresh_t b_thresh(input int unsigned k);
    int unsigned lo;
    int unsigned hi;
    lo = (k * FULL_SCALE) / B_MAX_LEVEL;
    hi = ((k + 1) * FULL_SCALE) / B_MAX_LEVEL;
    return thresh_t'(lo + hi);
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/r332t_blend.sv =====
`default_nettype none

module r332t_blend (
  input  wire r332t_pkg::chan_t chan,
  input  wire r332t_pkg::chan_t alpha,
  output r332t_pkg::chan_t      blended
);

  logic [7:0]                inv_chan;
  r332t_pkg::blend_num_t     prod;
  r332t_pkg::blend_num_t     num;
  r332t_pkg::blend_num_t     sum;

  // Numerator c*a + 255*(255-a) + 127, rewritten as bias - a*(255-c)
  assign inv_chan = 8'(r332t_pkg::FULL_SCALE) - chan;
  assign prod     = 16'(alpha) * 16'(inv_chan);
  assign num      = 16'(r332t_pkg::BLEND_BIAS) - prod;

  // Divide by 255: (n + (n >> 8) + 1) >> 8 is exact over the numerator's range
  assign sum     = num + {8'd0, num[15:8]} + 16'd1;
  assign blended = sum[15:8];

endmodule

`default_nettype wire

// ===== hw/rtl/r332t_quant.sv =====
`default_nettype none

module r332t_quant (
  input  wire r332t_pkg::chan_t w_red,
  input  wire r332t_pkg::chan_t w_green,
  input  wire r332t_pkg::chan_t w_blue,
  output logic [7:0]            packed_pixel
);

  r332t_pkg::thresh_t   red_x2;
  r332t_pkg::thresh_t   green_x2;
  r332t_pkg::thresh_t   blue_x2;
  r332t_pkg::rg_level_t lvl_red;
  r332t_pkg::rg_level_t lvl_green;
  r332t_pkg::b_level_t  lvl_blue;

  assign red_x2   = {w_red,   1'b0};
  assign green_x2 = {w_green, 1'b0};
  assign blue_x2  = {w_blue,  1'b0};

  // Count the midpoints exceeded; thresholds rise, so the count is the level
  always_comb begin
    lvl_red   = '0;
    lvl_green = '0;
    lvl_blue  = '0;
    for (int unsigned k = 0; k < r332t_pkg::RG_MAX_LEVEL; k++) begin
      if (red_x2 > r332t_pkg::rg_thresh(k)) begin
        lvl_red = lvl_red + 3'd1;
      end
      if (green_x2 > r332t_pkg::rg_thresh(k)) begin
        lvl_green = lvl_green + 3'd1;
      end
    end
    for (int unsigned k = 0; k < r332t_pkg::B_MAX_LEVEL; k++) begin
      if (blue_x2 > r332t_pkg::b_thresh(k)) begin
        lvl_blue = lvl_blue + 2'd1;
      end
    end
  end

  // Pack as RRRGGGBB
  assign packed_pixel = {lvl_red, lvl_green, lvl_blue};

endmodule

`default_nettype wire

// ===== hw/rtl/rgba_to_rgb332_thumbnail_pixel.sv =====
// Channel   Direction  Handshake            Payload
// in_       input      in_valid / in_stall  r332t_pkg::pixel_in_t  (RGBA, row_end)
// out_      output     out_valid / out_stall r332t_pkg::pixel_out_t (RRRGGGBB, row_end_out)
//
// One pixel per cycle while out_stall is low; input register feeds result register.
// The rate is set by the single input-register to result-register pass (blend
// multiply, divide-by-255 adder, threshold compares).
// Reset clears both stage valid flags; no pixel is in flight after reset.
// A stalled result holds its register; the input register still takes a pixel,
// so in_stall rises only when both registers are full and out_stall is high.
`default_nettype none

module rgba_to_rgb332_thumbnail_pixel (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  output logic                    in_stall,
  input  wire r332t_pkg::pixel_in_t in_data,
  output logic                    out_valid,
  input  wire                     out_stall,
  output r332t_pkg::pixel_out_t   out_data
);

  logic                  s1_v_r;
  r332t_pkg::pixel_in_t  s1_data_r;
  logic                  out_v_r;
  r332t_pkg::pixel_out_t out_data_r;
  r332t_pkg::pixel_out_t out_data_nxt;
  logic                  out_ready;
  logic                  s1_ready;
  r332t_pkg::chan_t      w_red;
  r332t_pkg::chan_t      w_green;
  r332t_pkg::chan_t      w_blue;
  logic [7:0]            packed_pixel;

  // Advance when the next stage is empty or moving on
  assign out_ready = !out_v_r || !out_stall;
  assign s1_ready  = !s1_v_r || out_ready;
  assign in_stall  = !s1_ready;

  // Blend each colour channel over white
  r332t_blend u_blend_red (
    .chan    (s1_data_r.red),
    .alpha   (s1_data_r.alpha),
    .blended (w_red)
  );

  r332t_blend u_blend_green (
    .chan    (s1_data_r.green),
    .alpha   (s1_data_r.alpha),
    .blended (w_green)
  );

  r332t_blend u_blend_blue (
    .chan    (s1_data_r.blue),
    .alpha   (s1_data_r.alpha),
    .blended (w_blue)
  );

  // Quantize and pack
  r332t_quant u_quant (
    .w_red        (w_red),
    .w_green      (w_green),
    .w_blue       (w_blue),
    .packed_pixel (packed_pixel)
  );

  assign out_data_nxt.packed_pixel = packed_pixel;
  assign out_data_nxt.row_end_out  = s1_data_r.row_end;

  // Stage valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_v_r <= in_valid;
      end
      if (out_ready) begin
        out_v_r <= s1_v_r;
      end
    end
  end

  // Capture the transaction payloads; hold them while stalled
  always_ff @(posedge clk) begin
    if (in_valid && s1_ready) begin
      s1_data_r <= in_data;
    end
    if (s1_v_r && out_ready) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ===== hw/rtl/r332t_checker.sv =====
`default_nettype none

module r332t_checker (
  input wire                       clk,
  input wire                       rst_n,
  input wire                       in_valid,
  input wire                       in_stall,
  input wire r332t_pkg::pixel_in_t  in_data,
  input wire                       out_valid,
  input wire                       out_stall,
  input wire r332t_pkg::pixel_out_t out_data
);

  // No result straight after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // Transparent pixel reaches the output as white once the result register can load
  a_transparent_white: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_data.alpha == 8'd0) ##1 (!out_valid || !out_stall)
    |=> out_valid && out_data.packed_pixel == 8'hFF)
    else $error("transparent pixel not white");

  // Carry the row end mark with its pixel
  a_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) ##1 (!out_valid || !out_stall)
    |=> out_valid && out_data.row_end_out == $past(in_data.row_end, 2))
    else $error("row end mark lost");

  // Both registers full and output stalled: refuse the next transaction
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) ##1 (out_valid && out_stall) |-> in_stall)
    else $error("input accepted with no room");

endmodule

bind rgba_to_rgb332_thumbnail_pixel r332t_checker u_r332t_checker (.*);

`default_nettype wire

// ===== sim/rgb332_pixel_checker.sv =====
`timescale 1ns / 100ps

module rgb332_pixel_checker (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  input  wire                   in_stall,
  input  r332t_pkg::pixel_in_t  in_data,
  input  wire                   out_valid,
  input  wire                   out_stall,
  input  r332t_pkg::pixel_out_t out_data,
  output int                    fail_count,
  output int                    pending_count
);

  r332t_pkg::pixel_out_t expected_pixels[$];

  initial begin
    fail_count    = 0;
    pending_count = 0;
  end

  // Composite one channel over white, rounding the division by 255 to nearest
  function automatic int unsigned blend_over_white(input logic [7:0] chan,
                                                   input logic [7:0] alpha);
    int unsigned num;
    num = int'(chan) * int'(alpha)
          + r332t_pkg::FULL_SCALE * (r332t_pkg::FULL_SCALE - int'(alpha))
          + r332t_pkg::HALF_ROUND;
    return num / r332t_pkg::FULL_SCALE;
  endfunction

  // Pick the level whose decoded value is closest; keep the lower one on a tie
  function automatic int unsigned nearest_level(input int unsigned w,
                                                input int unsigned top);
    int unsigned best;
    int unsigned best_dist;
    int unsigned decoded;
    int unsigned diff;
    best      = 0;
    best_dist = 1000;
    for (int unsigned k = 0; k <= top; k++) begin
      decoded = (k * r332t_pkg::FULL_SCALE) / top;
      diff    = (w > decoded) ? w - decoded : decoded - w;
      if (diff < best_dist) begin
        best      = k;
        best_dist = diff;
      end
    end
    return best;
  endfunction

  function automatic r332t_pkg::pixel_out_t quantize_pixel(input r332t_pkg::pixel_in_t px);
    r332t_pkg::pixel_out_t res;
    r332t_pkg::rg_level_t  red_lvl;
    r332t_pkg::rg_level_t  green_lvl;
    r332t_pkg::b_level_t   blue_lvl;
    red_lvl   = r332t_pkg::rg_level_t'(nearest_level(blend_over_white(px.red, px.alpha),
                                                     r332t_pkg::RG_MAX_LEVEL));
    green_lvl = r332t_pkg::rg_level_t'(nearest_level(blend_over_white(px.green, px.alpha),
                                                     r332t_pkg::RG_MAX_LEVEL));
    blue_lvl  = r332t_pkg::b_level_t'(nearest_level(blend_over_white(px.blue, px.alpha),
                                                    r332t_pkg::B_MAX_LEVEL));
    res.packed_pixel = {red_lvl, green_lvl, blue_lvl};
    res.row_end_out  = px.row_end;
    return res;
  endfunction

  // Compare each result transaction first, then queue the prediction for a new pixel
  always @(posedge clk) begin
    r332t_pkg::pixel_out_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_pixels.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected result %02h row_end %0b at %0t",
                     out_data.packed_pixel, out_data.row_end_out, $realtime);
          fail_count++;
        end else begin
          want = expected_pixels.pop_front();
          if (out_data.packed_pixel !== want.packed_pixel ||
              out_data.row_end_out !== want.row_end_out) begin
            if (fail_count < 10)
              $display("pixel mismatch at %0t: expected %02h/%0b, got %02h/%0b", $realtime,
                       want.packed_pixel, want.row_end_out,
                       out_data.packed_pixel, out_data.row_end_out);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall)
        expected_pixels.push_back(quantize_pixel(in_data));
    end
    pending_count <= expected_pixels.size();
  end

endmodule

// ===== sim/rgba_to_rgb332_thumbnail_pixel_test.sv =====
`timescale 1ns / 100ps

module rgba_to_rgb332_thumbnail_pixel_test;

  localparam int CYCLE_LIMIT     = 400000;
  localparam int ITEMS_PER_PHASE = 372;
  localparam int NUM_DIRECTED    = 18;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  r332t_pkg::pixel_in_t  in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  r332t_pkg::pixel_out_t out_data;

  int fail_count;
  int pending_count;
  int idle_pct    = 0;
  int stall_pct   = 0;
  int cycle_count = 0;

  int idle_table  [4] = '{0, 52, 0, 16};
  int stall_table [4] = '{0, 0, 52, 16};

  // Extremes, transparent and opaque pixels, and channel values on level boundaries
  r332t_pkg::pixel_in_t directed_pixels [NUM_DIRECTED] = '{
    '{8'd0,   8'd0,   8'd0,   8'd255, 1'b0},
    '{8'd255, 8'd255, 8'd255, 8'd255, 1'b1},
    '{8'd54,  8'd127, 8'd200, 8'd255, 1'b0},
    '{8'd55,  8'd128, 8'd201, 8'd255, 1'b0},
    '{8'd36,  8'd109, 8'd85,  8'd255, 1'b1},
    '{8'd35,  8'd108, 8'd42,  8'd255, 1'b0},
    '{8'd43,  8'd128, 8'd127, 8'd255, 1'b0},
    '{8'd170, 8'd85,  8'd128, 8'd255, 1'b0},
    '{8'd0,   8'd0,   8'd0,   8'd0,   1'b0},
    '{8'd12,  8'd200, 8'd77,  8'd0,   1'b1},
    '{8'd255, 8'd255, 8'd255, 8'd0,   1'b0},
    '{8'd0,   8'd0,   8'd0,   8'd1,   1'b0},
    '{8'd0,   8'd255, 8'd128, 8'd128, 1'b0},
    '{8'd0,   8'd0,   8'd0,   8'd254, 1'b1},
    '{8'd255, 8'd0,   8'd0,   8'd255, 1'b0},
    '{8'd0,   8'd255, 8'd0,   8'd255, 1'b0},
    '{8'd0,   8'd0,   8'd255, 8'd255, 1'b1},
    '{8'd128, 8'd128, 8'd128, 8'd127, 1'b0}
  };

  rgba_to_rgb332_thumbnail_pixel DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  rgb332_pixel_checker pixel_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stall the result channel at random
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Offer one pixel after an optional idle gap and hold it until the transaction completes
  task automatic send_pixel(input r332t_pkg::pixel_in_t px);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    do @(posedge clk); while (in_stall);
  endtask

  initial begin
    r332t_pkg::pixel_in_t px;
    int                   alpha_sel;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int phase = 0; phase < 4; phase++) begin
      idle_pct  = idle_table[phase];
      stall_pct = stall_table[phase];
      if (phase == 0) begin
        foreach (directed_pixels[i])
          send_pixel(directed_pixels[i]);
      end
      // Random pixels; bias alpha towards fully transparent and fully opaque
      repeat (ITEMS_PER_PHASE) begin
        alpha_sel  = $urandom_range(7);
        px.red     = 8'($urandom_range(255));
        px.green   = 8'($urandom_range(255));
        px.blue    = 8'($urandom_range(255));
        px.alpha   = (alpha_sel == 0) ? 8'd0 :
                     (alpha_sel == 1) ? 8'd255 : 8'($urandom_range(255));
        px.row_end = ($urandom_range(15) == 0);
        send_pixel(px);
      end
    end
    in_valid <= 1'b0;

    // Drain outstanding results, then let the pipeline settle
    do @(posedge clk); while (pending_count != 0);
    repeat (20) @(posedge clk);

    if (fail_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
